[rtl/chs_pkg.sv]
// Shared constants, codes and types of the chained hash set engine.
// Used by chs_slot_ram, chained_hash_set_engine and tb_top; depends on nothing.
package chs_pkg;

    // Table geometry. BUCKETS and WAYS are powers of two, so a slot address
    // is the bucket index followed by the way index.
    localparam int BUCKETS  = 16;
    localparam int WAYS     = 8;
    localparam int KEY_BITS = 32;

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int ADDR_W = $clog2(SLOTS);

    // Port field widths.
    localparam int MODE_W   = 2;
    localparam int IN_KEY_W = 32;
    localparam int RANK_W   = 7;
    localparam int CNT_W    = 8;
    localparam int STAT_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_GET      = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One access of the slot memory: a write when we is set, and always a read.
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [KEY_BITS-1:0] wdata;
    } ram_req_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                    input logic [WAY_W-1:0] way);
        return {bkt, way};
    endfunction

endpackage

[rtl/chs_slot_ram.sv]
// Key slot storage of the chained hash set engine: a single-port synchronous
// memory whose read data is registered. Depends on chs_pkg.
module chs_slot_ram (
    input  logic                      clk,
    input  chs_pkg::ram_req_t         req,
    output logic [chs_pkg::KEY_BITS-1:0] rdata
);
    import chs_pkg::*;

    logic [KEY_BITS-1:0] slot_mem [SLOTS];
    logic [KEY_BITS-1:0] rdata_reg;

    // Read-before-write: a read of the entry being written returns the old key.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            slot_mem[req.addr] <= req.wdata;
        end
        rdata_reg <= slot_mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/chained_hash_set_engine.sv]
// Chained hash set engine: a set of keys in a bucketed table with sorted buckets.
// Top level; depends on chs_pkg and chs_slot_ram.
//
// One transaction is taken when start is high and busy is low; its result appears
// on hit, key_out, count and status for exactly one cycle with done high, and the
// receiver cannot stall it. One transaction is worked on at a time, and every
// slot access goes through the one port of the slot memory. Insert, remove and
// contains read and compare the slots of the key's bucket in order (at most
// WAYS) until the key or a larger key is found or the scan runs past the last
// key. Insert then moves each key above the new key's place up by one, from the
// top, and writes the key; remove moves each key above the removed one down by
// one. Get passes over the fill counts of the buckets in order until it reaches
// the bucket that holds the rank, then reads the key there; an out-of-range rank
// never raises busy. The result follows in the cycle after the last busy cycle.
// busy falls in the cycle where done is high, so the next transaction may start
// there.
module chained_hash_set_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [chs_pkg::MODE_W-1:0]    mode,
    input  logic [chs_pkg::IN_KEY_W-1:0]  key,
    input  logic [chs_pkg::RANK_W-1:0]    rank,
    output logic                          done,
    output logic                          hit,
    output logic [chs_pkg::IN_KEY_W-1:0]  key_out,
    output logic [chs_pkg::CNT_W-1:0]     count,
    output logic [chs_pkg::STAT_W-1:0]    status
);
    import chs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CMP = 8'b0000_0100,
        S_SHIFT_RD = 8'b0000_1000,
        S_SHIFT_WR = 8'b0001_0000,
        S_PUT      = 8'b0010_0000,
        S_WALK     = 8'b0100_0000,
        S_GET_WAIT = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic [FILL_W-1:0]   pos_reg, pos_next;
    logic [BKT_W-1:0]    walk_reg, walk_next;
    logic [CNT_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FILL_W-1:0]   fill_reg [BUCKETS];
    logic                done_reg, done_next;
    logic                hit_reg, hit_next;
    logic [KEY_BITS-1:0] kout_reg, kout_next;
    status_t             status_reg, status_next;

    // Fill count update of the current key's bucket.
    logic                fill_we;
    logic [FILL_W-1:0]   fill_val;

    ram_req_t            ram_req;
    logic [KEY_BITS-1:0] ram_rdata;

    logic [BKT_W-1:0]    bkt;
    logic [FILL_W-1:0]   fill_cur;
    logic [FILL_W-1:0]   fill_walk;
    logic [CNT_W-1:0]    walk_end;
    logic [CNT_W-1:0]    walk_off;

    // Outcome of the bucket scan, decided in either scan state.
    logic                scan_end;
    logic                scan_hit;
    logic [FILL_W-1:0]   scan_pos;

    chs_slot_ram u_slot_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign bkt       = key_reg[BKT_W-1:0];
    assign fill_cur  = fill_reg[bkt];
    assign fill_walk = fill_reg[walk_reg];
    assign walk_end  = acc_reg + CNT_W'(fill_walk);
    assign walk_off  = CNT_W'(rank_reg) - acc_reg;

    always_comb
    begin
        scan_end = 1'b0;
        scan_hit = 1'b0;
        scan_pos = idx_reg;
        if (state_reg == S_SCAN_RD && idx_reg >= fill_cur)
        begin
            scan_end = 1'b1;
        end
        else if (state_reg == S_SCAN_CMP)
        begin
            if (ram_rdata == key_reg)
            begin
                scan_end = 1'b1;
                scan_hit = 1'b1;
            end
            else if (ram_rdata > key_reg)
            begin
                scan_end = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        rank_next   = rank_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        walk_next   = walk_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        kout_next   = kout_reg;
        status_next = status_reg;
        fill_we     = 1'b0;
        fill_val    = fill_cur;
        ram_req.we    = 1'b0;
        ram_req.addr  = slot_addr(bkt, idx_reg[WAY_W-1:0]);
        ram_req.wdata = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode_t'(mode);
                    key_next  = KEY_BITS'(key);
                    rank_next = rank;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    kout_next = '0;
                    status_next = ST_OK;
                    if (mode_t'(mode) == MODE_GET)
                    begin
                        if (CNT_W'(rank) >= count_reg)
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            walk_next  = '0;
                            acc_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (!scan_end)
                begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (!scan_end)
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                // Insert moves keys up from the top, remove moves them down.
                if (mode_reg == MODE_INSERT)
                begin
                    ram_req.addr = slot_addr(bkt, WAY_W'(idx_reg - FILL_W'(1)));
                end
                else
                begin
                    ram_req.addr = slot_addr(bkt, WAY_W'(idx_reg + FILL_W'(1)));
                end
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata;
                if (mode_reg == MODE_INSERT)
                begin
                    idx_next = idx_reg - FILL_W'(1);
                    if (idx_reg - FILL_W'(1) == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + FILL_W'(1);
                    if (({1'b0, idx_reg} + (FILL_W + 1)'(2)) < {1'b0, fill_cur})
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        fill_we    = 1'b1;
                        fill_val   = fill_cur - FILL_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        hit_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_PUT:
            begin
                ram_req.we   = 1'b1;
                ram_req.addr = slot_addr(bkt, pos_reg[WAY_W-1:0]);
                fill_we      = 1'b1;
                fill_val     = fill_cur + FILL_W'(1);
                count_next   = count_reg + CNT_W'(1);
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            S_WALK:
            begin
                ram_req.addr = slot_addr(walk_reg, walk_off[WAY_W-1:0]);
                if (CNT_W'(rank_reg) < walk_end)
                begin
                    state_next = S_GET_WAIT;
                end
                else
                begin
                    acc_next  = walk_end;
                    walk_next = walk_reg + BKT_W'(1);
                end
            end

            S_GET_WAIT:
            begin
                kout_next  = ram_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Common handling once the scan has found the key or its place.
        if (scan_end)
        begin
            pos_next = scan_pos;
            hit_next = scan_hit;
            case (mode_reg)
                MODE_INSERT:
                begin
                    if (scan_hit)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (fill_cur >= FILL_W'(WAYS))
                    begin
                        status_next = ST_FULL;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next = fill_cur;
                        if (fill_cur > scan_pos)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                end

                MODE_REMOVE:
                begin
                    idx_next = scan_pos;
                    if (!scan_hit)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (({1'b0, scan_pos} + (FILL_W + 1)'(1)) < {1'b0, fill_cur})
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        fill_we    = 1'b1;
                        fill_val   = fill_cur - FILL_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end

                default:
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (fill_we)
            begin
                fill_reg[bkt] <= fill_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        rank_reg   <= rank_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        walk_reg   <= walk_next;
        acc_reg    <= acc_next;
        hit_reg    <= hit_next;
        kout_reg   <= kout_next;
        status_reg <= status_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign hit     = hit_reg;
    assign key_out = IN_KEY_W'(kout_reg);
    assign count   = count_reg;
    assign status  = status_reg;

    // A result is always delivered with the engine back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the engine is busy");

    // The key count never exceeds the table capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("key count beyond table capacity");

    // A dropped insert leaves the count unchanged and reports no hit.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg == ST_FULL |-> !hit && $stable(count_reg) && mode_reg == MODE_INSERT)
        else $error("bucket-full result is inconsistent");

    // An out-of-range rank returns a zero key.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg == ST_RANGE |-> kout_reg == '0 && !hit)
        else $error("out-of-range get returned data");

    // The rank walk never passes the last bucket.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && CNT_W'(rank_reg) >= walk_end |-> walk_reg != BKT_W'(BUCKETS - 1))
        else $error("rank walk ran past the last bucket");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the chained hash set engine: a directed table, then
// about 800 random transactions with random gaps, checked against a local set model.
// Depends on chs_pkg and the chained_hash_set_engine RTL.
module tb_top;
    import chs_pkg::*;

    typedef struct {
        logic                hit;
        logic [IN_KEY_W-1:0] key_out;
        logic [CNT_W-1:0]    count;
        status_t             status;
    } set_result_t;

    typedef struct {
        mode_t             op;
        logic [IN_KEY_W-1:0] k;
        logic [RANK_W-1:0] r;
        bit                typed;
        set_result_t       want;
    } op_row_t;

    localparam int RANDOM_OPS  = 800;
    localparam int STALL_LIMIT = 2000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [MODE_W-1:0]   mode = '0;
    logic [IN_KEY_W-1:0] key = '0;
    logic [RANK_W-1:0]   rank = '0;
    logic                busy;
    logic                done;
    logic                hit;
    logic [IN_KEY_W-1:0] key_out;
    logic [CNT_W-1:0]    count;
    logic [STAT_W-1:0]   status;

    // Local copy of the table contents, kept sorted within each bucket.
    logic [IN_KEY_W-1:0] set_keys[BUCKETS][WAYS];
    int                  set_fill[BUCKETS];
    int                  set_total;

    set_result_t pending_results[$];
    op_row_t     directed_rows[$];

    int fails;
    int ops_sent;
    int results_seen;
    int full_drops;
    int range_errors;
    int peak_count;
    int stall_cycles;

    chained_hash_set_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .key     (key),
        .rank    (rank),
        .done    (done),
        .hit     (hit),
        .key_out (key_out),
        .count   (count),
        .status  (status)
    );

    always #4 clk = ~clk;

    function automatic set_result_t apply_set_op(mode_t op, logic [IN_KEY_W-1:0] k,
                                                 logic [RANK_W-1:0] r);
        set_result_t res;
        int b;
        int n;
        int pos;
        int ins;
        int acc;
        res.hit = 1'b0;
        res.key_out = '0;
        res.status = ST_OK;
        b = int'(k % BUCKETS);
        n = set_fill[b];
        if (op == MODE_GET) begin
            if (int'(r) >= set_total) begin
                res.status = ST_RANGE;
            end
            else begin
                acc = 0;
                for (int i = 0; i < BUCKETS; i++) begin
                    if (int'(r) < acc + set_fill[i]) begin
                        res.key_out = set_keys[i][int'(r) - acc];
                        break;
                    end
                    acc += set_fill[i];
                end
            end
        end
        else begin
            pos = n;
            ins = n;
            for (int i = 0; i < n; i++) begin
                if (set_keys[b][i] == k) begin
                    pos = i;
                    ins = i;
                    break;
                end
                if (set_keys[b][i] > k) begin
                    ins = i;
                    break;
                end
            end
            res.hit = (pos < n);
            if (op == MODE_INSERT && !res.hit) begin
                if (n >= WAYS) begin
                    res.status = ST_FULL;
                end
                else begin
                    for (int j = n; j > ins; j--)
                        set_keys[b][j] = set_keys[b][j-1];
                    set_keys[b][ins] = k;
                    set_fill[b] = n + 1;
                    set_total++;
                end
            end
            else if (op == MODE_REMOVE && res.hit) begin
                for (int j = pos; j < n - 1; j++)
                    set_keys[b][j] = set_keys[b][j+1];
                set_fill[b] = n - 1;
                set_total--;
            end
        end
        res.count = CNT_W'(set_total);
        return res;
    endfunction

    // Mostly keys from a narrow range per bucket, so buckets collide and fill up.
    function automatic logic [IN_KEY_W-1:0] pick_key();
        int sel;
        int b;
        logic [IN_KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        b = $urandom_range(0, BUCKETS - 1);
        if (sel == 0)
            k = $urandom;
        else if (sel == 1)
            k = ~(IN_KEY_W'($urandom_range(0, 5)) * BUCKETS) - IN_KEY_W'(BUCKETS - 1 - b);
        else
            k = IN_KEY_W'($urandom_range(0, 11)) * BUCKETS + IN_KEY_W'(b);
        return k;
    endfunction

    function automatic logic [IN_KEY_W-1:0] pick_present_key();
        int b;
        do
            b = $urandom_range(0, BUCKETS - 1);
        while (set_fill[b] == 0);
        return set_keys[b][$urandom_range(0, set_fill[b] - 1)];
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 0;
        else if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(mode_t op, logic [IN_KEY_W-1:0] k, logic [RANK_W-1:0] r,
                           bit typed, logic h, logic [IN_KEY_W-1:0] ko, int cnt,
                           status_t st);
        op_row_t row;
        row.op = op;
        row.k = k;
        row.r = r;
        row.typed = typed;
        row.want.hit = h;
        row.want.key_out = ko;
        row.want.count = CNT_W'(cnt);
        row.want.status = st;
        directed_rows.push_back(row);
    endtask

    // Holds start high until the transaction is taken, then records its expected result.
    // start is left high so that back-to-back transactions need no extra step.
    task automatic issue(mode_t op, logic [IN_KEY_W-1:0] k, logic [RANK_W-1:0] r,
                         bit typed, set_result_t typed_want);
        set_result_t res;
        start <= 1'b1;
        mode <= op;
        key <= k;
        rank <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = apply_set_op(op, k, r);
        pending_results.push_back(typed ? typed_want : res);
        ops_sent++;
        if (res.status == ST_FULL)
            full_drops++;
        if (res.status == ST_RANGE)
            range_errors++;
        if (set_total > peak_count)
            peak_count = set_total;
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string field, logic [IN_KEY_W-1:0] got,
                                   logic [IN_KEY_W-1:0] want);
        $display("mismatch on result %0d, %s: got %0h, expected %0h",
                 results_seen, field, got, want);
        fails++;
    endtask

    always @(posedge clk) begin
        set_result_t want;
        if (rst_n && done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", key_out, '0);
            end
            else begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (key_out !== want.key_out)
                    report_mismatch("key_out", key_out, want.key_out);
                if (count !== want.count)
                    report_mismatch("count", count, want.count);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        set_result_t no_want;
        op_row_t     row;
        mode_t       op;
        logic [IN_KEY_W-1:0] k;
        logic [RANK_W-1:0]   r;
        int sel;
        int burst_left;

        fails = 0;
        ops_sent = 0;
        results_seen = 0;
        full_drops = 0;
        range_errors = 0;
        peak_count = 0;
        stall_cycles = 0;
        set_total = 0;
        burst_left = 0;
        for (int i = 0; i < BUCKETS; i++)
            set_fill[i] = 0;
        no_want.hit = 1'b0;
        no_want.key_out = '0;
        no_want.count = '0;
        no_want.status = ST_OK;

        // Empty set, the key extremes, then one bucket filled past its capacity.
        add_row(MODE_GET,      32'h0000_0000, 7'd0,   1, 0, 32'h0,         0,  ST_RANGE);
        add_row(MODE_CONTAINS, 32'h1234_5678, 7'd0,   1, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_REMOVE,   32'hDEAD_BEEF, 7'd0,   1, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h0000_0000, 7'd0,   1, 0, 32'h0,         1,  ST_OK);
        add_row(MODE_INSERT,   32'hFFFF_FFFF, 7'd127, 1, 0, 32'h0,         2,  ST_OK);
        add_row(MODE_INSERT,   32'h0000_0000, 7'd0,   1, 1, 32'h0,         2,  ST_OK);
        add_row(MODE_GET,      32'h0000_0000, 7'd0,   1, 0, 32'h0,         2,  ST_OK);
        add_row(MODE_GET,      32'hFFFF_FFFF, 7'd1,   1, 0, 32'hFFFF_FFFF, 2,  ST_OK);
        add_row(MODE_INSERT,   32'hFFFF_FFF5, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h0000_0005, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h8000_0005, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h7FFF_FFF5, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h0000_0015, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h5555_5555, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'hAAAA_AAA5, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h1234_5675, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_INSERT,   32'h0000_0025, 7'd0,   1, 0, 32'h0,         10, ST_FULL);
        add_row(MODE_CONTAINS, 32'h8000_0005, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_GET,      32'h0000_0000, 7'd127, 1, 0, 32'h0,         10, ST_RANGE);
        add_row(MODE_GET,      32'h0000_0000, 7'd10,  1, 0, 32'h0,         10, ST_RANGE);
        add_row(MODE_GET,      32'h0000_0000, 7'd9,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_REMOVE,   32'h5555_5555, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_REMOVE,   32'h0000_0005, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_REMOVE,   32'h0000_0000, 7'd0,   0, 0, 32'h0,         0,  ST_OK);
        add_row(MODE_GET,      32'h0000_0000, 7'd3,   0, 0, 32'h0,         0,  ST_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            issue(row.op, row.k, row.r, row.typed, row.want);
            idle_for(pick_gap());
        end

        // The first half plus twenty lean on inserts so the table runs close to full,
        // the rest lean on removes so it drains again.
        for (int i = 0; i < RANDOM_OPS; i++) begin
            sel = $urandom_range(0, 99);
            if (i < RANDOM_OPS / 2 + 20)
                op = sel < 55 ? MODE_INSERT : sel < 70 ? MODE_REMOVE :
                     sel < 82 ? MODE_CONTAINS : MODE_GET;
            else
                op = sel < 20 ? MODE_INSERT : sel < 60 ? MODE_REMOVE :
                     sel < 78 ? MODE_CONTAINS : MODE_GET;
            if (op != MODE_INSERT && set_total > 0 && $urandom_range(0, 1) == 1)
                k = pick_present_key();
            else
                k = pick_key();
            if ($urandom_range(0, 3) == 0)
                r = RANK_W'($urandom_range(0, 127));
            else
                r = RANK_W'($urandom_range(0, set_total > 127 ? 127 : set_total));
            issue(op, k, r, 0, no_want);
            if (burst_left == 0 && $urandom_range(0, 99) == 0)
                burst_left = 30;
            if (burst_left > 0)
                burst_left--;
            else
                idle_for(pick_gap());
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * WAYS + 8) @(posedge clk);

        $display("%0d transactions, %0d results checked, peak of %0d keys held",
                 ops_sent, results_seen, peak_count);
        $display("%0d inserts dropped on a full bucket, %0d gets out of range",
                 full_drops, range_errors);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
